FILE: rtl/lpm6_pkg.sv
// Shared types and constants of the IPv6 multilevel LPM lookup.
`default_nettype none
package lpm6_pkg;

   localparam int MAX_CHUNKS   = 1024;
   localparam int KEY_W        = 128;
   localparam int TOP_W        = 16;
   localparam int TOP_DEPTH    = 1 << TOP_W;
   localparam int STRIDE_W     = 8;
   localparam int LOWER_LEVELS = 14;
   localparam int CHUNK_W      = 11;
   localparam int NH_W         = 8;
   localparam int ENTRY_W      = CHUNK_W + NH_W;
   localparam int LEVEL_W      = 4;
   localparam int INDEX_W      = 18;
   localparam int LEN_W        = 8;
   localparam int TOP_LEN      = 16;
   localparam int STRIDE_LEN   = 8;

   localparam int CHUNK_IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int LOWER_AW     = CHUNK_IDX_W + STRIDE_W;
   localparam int LOWER_DEPTH  = MAX_CHUNKS * (1 << STRIDE_W);
   localparam int CLEAR_LEN    = (LOWER_DEPTH > TOP_DEPTH) ? LOWER_DEPTH : TOP_DEPTH;
   localparam int CLR_W        = $clog2(CLEAR_LEN);

   localparam int REQ_FIELDS_W = 2 * 64 + LEVEL_W + INDEX_W + CHUNK_W + NH_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = NH_W + LEN_W;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_WRITE  = 1'b1;

   // one item as it moves down the chain of level cells
   typedef struct packed {
      logic                 valid;
      logic                 mode;
      logic [KEY_W-1:0]     key;      // consumed from the top, shifted left per level
      logic [LEVEL_W-1:0]   wr_level; // target tag, counts down per level cell
      logic [INDEX_W-1:0]   wr_index;
      logic [ENTRY_W-1:0]   wr_entry;
      logic [ENTRY_W-1:0]   entry;    // entry found so far
      logic [LEN_W-1:0]     len;
   } lpm6_item_type;

   typedef struct packed {
      logic             active;
      logic [CLR_W-1:0] addr;
   } lpm6_clear_type;

endpackage
`default_nettype wire

FILE: rtl/lpm6_root_cell.sv
// Root cell: the 16-bit top-level table, first step of every lookup.
`default_nettype none
module lpm6_root_cell
   import lpm6_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           adv,
   input  wire lpm6_clear_type clear,
   input  wire lpm6_item_type  up_item,
   output lpm6_item_type       down_item
);

   logic [ENTRY_W-1:0] mem [TOP_DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;
   lpm6_item_type      stage_ff;
   lpm6_item_type      stage_in;
   logic [TOP_W-1:0]   rd_addr;
   logic               wr_hit;

   assign rd_addr = up_item.key[KEY_W-1 -: TOP_W];
   assign wr_hit  = up_item.valid && (up_item.mode == MODE_WRITE) &&
                    (up_item.wr_level == '0) && (32'(up_item.wr_index) < TOP_DEPTH);

   always_ff @(posedge clock) begin
      if (clear.active) begin
         if (32'(clear.addr) < TOP_DEPTH) begin
            mem[clear.addr[TOP_W-1:0]] <= '0;
         end
      end else if (adv) begin
         if (wr_hit) begin
            mem[up_item.wr_index[TOP_W-1:0]] <= up_item.wr_entry;
         end
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      stage_in     = up_item;
      stage_in.key = up_item.key << TOP_W;
      stage_in.len = LEN_W'(TOP_LEN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in;
      end
   end

   always_comb begin
      down_item       = stage_ff;
      down_item.entry = rdata_ff;
   end

endmodule
`default_nettype wire

FILE: rtl/lpm6_level_cell.sv
// Level cell: one 8-bit-stride table, follows the chunk id of the level above.
`default_nettype none
module lpm6_level_cell
   import lpm6_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           adv,
   input  wire lpm6_clear_type clear,
   input  wire lpm6_item_type  up_item,
   output lpm6_item_type       down_item
);

   logic [ENTRY_W-1:0]  mem [LOWER_DEPTH];
   logic [ENTRY_W-1:0]  rdata_ff;
   lpm6_item_type       stage_ff;
   lpm6_item_type       stage_in;
   logic                took_ff;
   logic                oob_ff;
   logic [CHUNK_W-1:0]  chunk;
   logic [CHUNK_W-1:0]  chunk_m1;
   logic                look;
   logic                oob;
   logic                wr_hit;
   logic [LOWER_AW-1:0] rd_addr;

   assign chunk    = up_item.entry[ENTRY_W-1 -: CHUNK_W];
   assign chunk_m1 = chunk - CHUNK_W'(1);
   assign look     = up_item.valid && (up_item.mode == MODE_LOOKUP) && (chunk != '0);
   assign oob      = 32'(chunk) > MAX_CHUNKS;
   assign rd_addr  = {chunk_m1[CHUNK_IDX_W-1:0], up_item.key[KEY_W-1 -: STRIDE_W]};
   assign wr_hit   = up_item.valid && (up_item.mode == MODE_WRITE) &&
                     (up_item.wr_level == LEVEL_W'(1)) &&
                     (32'(up_item.wr_index) < LOWER_DEPTH);

   always_ff @(posedge clock) begin
      if (clear.active) begin
         if (32'(clear.addr) < LOWER_DEPTH) begin
            mem[clear.addr[LOWER_AW-1:0]] <= '0;
         end
      end else if (adv) begin
         if (wr_hit) begin
            mem[up_item.wr_index[LOWER_AW-1:0]] <= up_item.wr_entry;
         end
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      stage_in     = up_item;
      stage_in.key = up_item.key << STRIDE_W;
      if (up_item.wr_level != '0) begin
         stage_in.wr_level = up_item.wr_level - LEVEL_W'(1);
      end
      if (look) begin
         stage_in.len = up_item.len + LEN_W'(STRIDE_LEN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
         took_ff        <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in;
         took_ff  <= look;
         oob_ff   <= oob;
      end
   end

   // chunk id beyond range reads as an empty entry
   always_comb begin
      down_item = stage_ff;
      if (took_ff) begin
         down_item.entry = oob_ff ? '0 : rdata_ff;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/ipv6_multilevel_lpm_lookup.sv
// IPv6 longest-prefix-match lookup: root cell plus a chain of 14 level cells.
// A request is registered in the root cell at the req transfer edge, then in each level cell
// in turn, then in the output register that drives rsp_tvalid.
// Throughput: one item per cycle; each level cell does one table access per cycle.
// The chain stalls only while a finished result is blocked at the output.
// Reset (synchronous): clears control, then a clearing pass over CLEAR_LEN (262144) addresses
// zeroes all tables; req_tready stays low meanwhile, csr writes are taken at any time.
`default_nettype none
module ipv6_multilevel_lpm_lookup
   import lpm6_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [63:0] key_high, [127:64] key_low, [131:128] level_select,
   // [149:132] entry_index, [160:150] entry_chunk, [168:161] entry_hop, rest zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,   // [0] mode
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [7:0] fwd_hop, [15:8] matched_length
   output logic                       rsp_tuser,   // [0] level_hit
   // default next hop register
   input  wire logic                  csr_we,
   input  wire logic [NH_W-1:0]       csr_wdata
);

   lpm6_item_type  chain [LOWER_LEVELS+1];
   lpm6_item_type  head;
   lpm6_item_type  tail;
   lpm6_clear_type clr_ff;
   lpm6_clear_type clr_in;
   logic           adv;
   logic           tail_rsp;

   logic [NH_W-1:0]  default_nh_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [NH_W-1:0]  rsp_nh_ff;
   logic [NH_W-1:0]  rsp_nh_in;
   logic [LEN_W-1:0] rsp_len_ff;
   logic [LEN_W-1:0] rsp_len_in;
   logic             rsp_hit_ff;
   logic             rsp_hit_in;

   // ---- clearing pass after reset ----
   always_comb begin
      clr_in = clr_ff;
      if (clr_ff.active) begin
         if (clr_ff.addr == CLR_W'(CLEAR_LEN - 1)) begin
            clr_in.active = 1'b0;
         end else begin
            clr_in.addr = clr_ff.addr + CLR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff.active <= 1'b1;
         clr_ff.addr   <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // ---- config register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         default_nh_ff <= '0;
      end else if (csr_we) begin
         default_nh_ff <= csr_wdata;
      end
   end

   // ---- chain advance: hold everything only when a result is stuck at the output ----
   assign tail     = chain[LOWER_LEVELS];
   assign tail_rsp = tail.valid && (tail.mode == MODE_LOOKUP);
   assign adv      = !(tail_rsp && rsp_valid_ff && !rsp_tready);
   assign req_tready = adv && !clr_ff.active;

   // unpack the request transfer into a chain item
   always_comb begin
      head          = '0;
      head.valid    = req_tvalid && req_tready;
      head.mode     = req_tuser;
      head.key      = {req_tdata[63:0], req_tdata[127:64]};
      head.wr_level = req_tdata[131:128];
      head.wr_index = req_tdata[149:132];
      head.wr_entry = {req_tdata[160:150], req_tdata[168:161]};
   end

   lpm6_root_cell u_root (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .clear     (clr_ff),
      .up_item   (head),
      .down_item (chain[0])
   );

   // level cells for prefix lengths 24 .. 128
   for (genvar g = 0; g < LOWER_LEVELS; g++) begin : g_level
      lpm6_level_cell u_level (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .clear     (clr_ff),
         .up_item   (chain[g]),
         .down_item (chain[g+1])
      );
   end

   // ---- result stage ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_nh_in    = rsp_nh_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_hit_in   = rsp_hit_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (adv && tail_rsp) begin
         rsp_valid_in = 1'b1;
         if (tail.entry[NH_W-1:0] != '0) begin
            rsp_nh_in  = tail.entry[NH_W-1:0];
            rsp_len_in = tail.len;
            rsp_hit_in = 1'b1;
         end else begin
            // no level answered: default next hop, length of the top level
            rsp_nh_in  = default_nh_ff;
            rsp_len_in = LEN_W'(TOP_LEN);
            rsp_hit_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_nh_ff  <= rsp_nh_in;
      rsp_len_ff <= rsp_len_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_nh_ff};
   assign rsp_tuser  = rsp_hit_ff;

endmodule
`default_nettype wire
